// ----- src/adsr_pkg.sv -----
// Shared constants and types for the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

    // Default widths
    localparam int TIME_WIDTH_DEF   = 24;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK    = 3'd0,
        REG_DECAY     = 3'd1,
        REG_SUSTAIN   = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_VOLUME    = 3'd4,
        REG_THRESHOLD = 3'd5,
        REG_HOLD      = 3'd6
    } cfg_reg_t;

    // Register reset values
    localparam int RST_ATTACK    = 0;
    localparam int RST_DECAY     = 24000;
    localparam int RST_SUSTAIN   = 32768;
    localparam int RST_RELEASE   = 48000;
    localparam int RST_VOLUME    = 16384;
    localparam int RST_THRESHOLD = 328;
    localparam int RST_HOLD      = 9600;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ----- src/adsr_in_if.sv -----
// Input channel: trigger and audio sample word with valid/ready.
`default_nettype none

interface adsr_in_if
    import adsr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] trigger_sample;
    logic signed [SAMPLE_WIDTH-1:0] audio_in;

    modport source (output valid, output trigger_sample, output audio_in, input ready);
    modport sink   (input valid, input trigger_sample, input audio_in, output ready);
endinterface

`default_nettype wire

// ----- src/adsr_out_if.sv -----
// Output channel: envelope and shaped audio word with valid/ready.
`default_nettype none

interface adsr_out_if
    import adsr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic        [SAMPLE_WIDTH-1:0] envelope_out;
    logic signed [SAMPLE_WIDTH-1:0] audio_out;

    modport source (output valid, output envelope_out, output audio_out, input ready);
    modport sink   (input valid, input envelope_out, input audio_out, output ready);
endinterface

`default_nettype wire

// ----- src/adsr_envelope_generator.sv -----
// ADSR envelope generator: sequencer with one shared multiplier and a serial divider.
// Sequence per word: outside the envelope S_EVAL then S_DONE; on a held sustain S_EVAL,
// S_VOL, S_AUD, S_DONE; on the attack ramp S_EVAL, S_DIV, S_VOL, S_AUD, S_DONE; on the
// decay and release ramps S_EVAL, S_MUL, S_SUM, S_DIV, S_VOL, S_AUD, S_DONE (one quotient bit per cycle in S_DIV).
// Input: one word at a time; the next word is taken once the sequencer
// is idle, while a finished result may still wait in the output register.
// Reset: registers take their documented defaults, envelope idle, counter and gate zero.
`default_nettype none

module adsr_envelope_generator
    import adsr_pkg::*;
#(
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    adsr_in_if.sink                                         samples,
    adsr_out_if.source                                      results,
    input  wire logic                                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                       cfg_index,
    input  wire logic [max_int(TIME_WIDTH,SAMPLE_WIDTH)-1:0] cfg_data
);
    localparam int TW    = TIME_WIDTH;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int CNT_W = TW + 2;
    localparam int NW    = TW + SW;
    localparam int AW    = max_int(TW, SW) + 1;
    localparam int PW    = AW + SW + 1;
    localparam int ONE   = 1 << (SW - 1);

    localparam logic [SW-1:0]        ONE_Q = SW'(ONE);
    localparam logic signed [PW-1:0] Q_MAX = PW'(ONE - 1);
    localparam logic signed [PW-1:0] Q_MIN = -Q_MAX - PW'(1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_SUM  = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_VOL  = 8'b0010_0000,
        S_AUD  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    // Configuration registers
    logic        [TW-1:0] attack_reg;
    logic        [TW-1:0] decay_reg;
    logic        [SW-1:0] sustain_reg;
    logic        [TW-1:0] release_reg;
    logic        [SW-1:0] volume_reg;
    logic signed [SW-1:0] threshold_reg;
    logic        [TW-1:0] hold_reg;

    // Derived from configuration
    logic [SW-1:0]    s_clamp_reg;
    logic [SW-1:0]    vol_clamp_reg;
    logic [TW:0]      ad_sum_reg;
    logic [CNT_W-1:0] total_reg;

    // Control state
    state_t           state_reg, state_next;
    logic             active_reg, active_next;
    logic             gate_reg, gate_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             load_out;

    // Datapath registers
    logic signed [SW-1:0] audio_reg;
    logic        [TW-1:0] u_reg;
    logic                 seg_decay_reg;
    logic        [SW-1:0] env_reg;
    logic        [SW-1:0] eout_reg;
    logic signed [PW-1:0] mul_p_reg;
    logic        [SW-1:0] envelope_out_reg;
    logic signed [SW-1:0] audio_out_reg;

    // Combinational signals
    logic                 in_fire;
    logic                 trig_high;
    logic                 in_env;
    logic                 in_attack;
    logic                 in_decay;
    logic                 hold;
    logic        [TW-1:0] t_low;
    logic        [TW-1:0] decay_u;
    logic [CNT_W-1:0]     rel_diff;
    logic signed [AW-1:0] mul_a;
    logic signed [SW:0]   mul_b;
    logic signed [PW-1:0] mul_res;
    logic        [SW-1:0] eout_slice;
    logic signed [PW-1:0] q_full;
    logic signed [PW-1:0] q_sat;
    logic                 div_start;
    logic        [NW-1:0] div_num;
    logic        [TW-1:0] div_den;
    logic                 div_done;
    logic        [SW-1:0] div_quot;

    assign in_fire   = samples.valid && (state_reg == S_IDLE);
    assign trig_high = samples.trigger_sample > threshold_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg    <= TW'(RST_ATTACK);
            decay_reg     <= TW'(RST_DECAY);
            sustain_reg   <= SW'(RST_SUSTAIN);
            release_reg   <= TW'(RST_RELEASE);
            volume_reg    <= SW'(RST_VOLUME);
            threshold_reg <= SW'(RST_THRESHOLD);
            hold_reg      <= TW'(RST_HOLD);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK:    attack_reg    <= cfg_data[TW-1:0];
                REG_DECAY:     decay_reg     <= cfg_data[TW-1:0];
                REG_SUSTAIN:   sustain_reg   <= cfg_data[SW-1:0];
                REG_RELEASE:   release_reg   <= cfg_data[TW-1:0];
                REG_VOLUME:    volume_reg    <= cfg_data[SW-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[SW-1:0];
                REG_HOLD:      hold_reg      <= cfg_data[TW-1:0];
                default:       ;
            endcase
        end
    end

    // Segment boundaries and clamped levels, refreshed every cycle
    always_ff @(posedge clk)
    begin
        s_clamp_reg   <= (sustain_reg > ONE_Q) ? ONE_Q : sustain_reg;
        vol_clamp_reg <= (volume_reg > ONE_Q) ? ONE_Q : volume_reg;
        ad_sum_reg    <= {1'b0, attack_reg} + {1'b0, decay_reg};
        total_reg     <= CNT_W'(attack_reg) + CNT_W'(decay_reg) + CNT_W'(release_reg);
    end

    // Segment decode for the current count
    assign in_env    = active_reg && (count_reg < total_reg);
    assign in_attack = count_reg < CNT_W'(attack_reg);
    assign in_decay  = count_reg < CNT_W'(ad_sum_reg);
    assign hold      = release_reg < hold_reg;
    assign t_low     = count_reg[TW-1:0];
    assign decay_u   = t_low - attack_reg;
    assign rel_diff  = total_reg - count_reg;

    // Shared multiplier operand select
    assign eout_slice = mul_p_reg[2*SW-2:SW-1];

    always_comb
    begin
        case (state_reg)
            S_VOL:
            begin
                mul_a = AW'(env_reg);
                mul_b = {1'b0, vol_clamp_reg};
            end
            S_AUD:
            begin
                mul_a = AW'(audio_reg);
                mul_b = {1'b0, eout_slice};
            end
            default:
            begin
                mul_a = AW'(u_reg);
                mul_b = {1'b0, s_clamp_reg};
            end
        endcase
    end

    assign mul_res = PW'(mul_a) * PW'(mul_b);

    // Scale back to Q1.15 and saturate
    assign q_full = mul_p_reg >>> (SW - 1);
    assign q_sat  = (q_full > Q_MAX) ? Q_MAX : ((q_full < Q_MIN) ? Q_MIN : q_full);

    // Divider request
    assign div_start = ((state_reg == S_EVAL) && in_env && in_attack) || (state_reg == S_SUM);

    always_comb
    begin
        if (state_reg == S_EVAL)
        begin
            div_num = NW'(t_low) << (SW - 1);
            div_den = attack_reg;
        end
        else if (seg_decay_reg)
        begin
            div_num = (NW'(decay_reg - u_reg) << (SW - 1)) + mul_p_reg[NW-1:0];
            div_den = decay_reg;
        end
        else
        begin
            div_num = mul_p_reg[NW-1:0];
            div_den = release_reg;
        end
    end

    adsr_div #(
        .TIME_WIDTH   (TW),
        .SAMPLE_WIDTH (SW)
    ) u_adsr_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        gate_next      = gate_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = S_EVAL;
                    if (trig_high)
                    begin
                        if (!gate_reg)
                        begin
                            count_next  = '0;
                            active_next = 1'b1;
                        end
                        gate_next = 1'b1;
                    end
                    else
                    begin
                        gate_next = 1'b0;
                    end
                end
            end
            S_EVAL:
            begin
                if (!in_env)
                begin
                    active_next = 1'b0;
                    state_next  = S_DONE;
                end
                else if (in_attack)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DIV;
                end
                else if (in_decay)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_MUL;
                end
                else
                begin
                    // release: counter stands still while the gate is held
                    if (!gate_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = hold ? S_VOL : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_VOL;
                end
            end
            S_VOL:
            begin
                state_next = S_AUD;
            end
            S_AUD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            gate_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            gate_reg      <= gate_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            audio_reg <= samples.audio_in;
        end

        if (state_reg == S_EVAL)
        begin
            seg_decay_reg <= in_decay;
            u_reg         <= in_decay ? decay_u : rel_diff[TW-1:0];
            env_reg       <= s_clamp_reg;
            if (!in_env)
            begin
                eout_reg  <= '0;
                mul_p_reg <= '0;
            end
        end

        if ((state_reg == S_MUL) || (state_reg == S_VOL) || (state_reg == S_AUD))
        begin
            mul_p_reg <= mul_res;
        end

        if (state_reg == S_AUD)
        begin
            eout_reg <= eout_slice;
        end

        if ((state_reg == S_DIV) && div_done)
        begin
            env_reg <= div_quot;
        end

        if (load_out)
        begin
            envelope_out_reg <= eout_reg;
            audio_out_reg    <= q_sat[SW-1:0];
        end
    end

    assign samples.ready        = (state_reg == S_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.envelope_out = envelope_out_reg;
    assign results.audio_out    = audio_out_reg;

endmodule

`default_nettype wire

// ----- src/adsr_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module adsr_div
    import adsr_pkg::*;
#(
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [TIME_WIDTH+SAMPLE_WIDTH-1:0]  num,
    input  wire logic [TIME_WIDTH-1:0]               den,
    output logic                                     done,
    output logic      [SAMPLE_WIDTH-1:0]             quot
);
    localparam int TW = TIME_WIDTH;
    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = $clog2(SW + 1);

    logic [TW-1:0] rem_reg;
    logic [SW-1:0] quo_reg;
    logic [TW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [TW:0]   shifted;
    logic [TW+1:0] diff;
    logic          ge;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[SW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = ~diff[TW+1];

    // Control: iteration count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[TW+SW-1:SW];
            quo_reg <= num[SW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[TW-1:0] : shifted[TW-1:0];
            quo_reg <= {quo_reg[SW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ----- src/adsr_checker.sv -----
// Port-level assertions for the ADSR envelope generator, bound to the top level.
`default_nettype none

module adsr_checker
    import adsr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic        [SAMPLE_WIDTH-1:0] envelope_out,
    input wire logic signed [SAMPLE_WIDTH-1:0] audio_out
);
    localparam logic [SAMPLE_WIDTH-1:0] ONE_Q = SAMPLE_WIDTH'(1 << (SAMPLE_WIDTH - 1));

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(envelope_out) && $stable(audio_out))
        else $error("result word changed while stalled");

    // One word at a time: busy straight after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready in the cycle after an accepted word");

    // Envelope never exceeds unity
    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> envelope_out <= ONE_Q)
        else $error("envelope above one");

    // Silent envelope gives silent audio
    a_zero_env: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (envelope_out == '0) |-> audio_out == '0)
        else $error("audio out non-zero with zero envelope");

endmodule

bind adsr_envelope_generator adsr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_adsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .envelope_out (results.envelope_out),
    .audio_out    (results.audio_out)
);

`default_nettype wire

// ----- tb/adsr_envelope_generator_tb.sv -----
// Self-checking testbench for the ADSR envelope generator: directed table, random notes, predictor.

module adsr_envelope_generator_tb
    import adsr_pkg::*;
;

    localparam int    RESET_CYCLES = 12;
    localparam int    QUIET_LIMIT  = 4000;
    localparam int    TAIL_CYCLES  = 32;
    localparam int    RANDOM_WORDS = 1400;
    localparam longint ONE         = 32768;

    // index past the end of the register list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // one shaped output word
    typedef struct packed {
        logic        [15:0] env;
        logic signed [15:0] aud;
    } shaped_t;

    // one line of the directed plan: a register write or a sample word
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [23:0]          data;
        logic signed [15:0]   trig;
        logic signed [15:0]   aud;
        logic                 known;
        shaped_t              want;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [TIME_WIDTH_DEF-1:0] cfg_data;

    adsr_in_if  sample_ch ();
    adsr_out_if result_ch ();

    adsr_envelope_generator i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // predictor copy of the registers
    logic [23:0]        attack_len  = 24'(RST_ATTACK);
    logic [23:0]        decay_len   = 24'(RST_DECAY);
    logic [15:0]        sustain_lvl = 16'(RST_SUSTAIN);
    logic [23:0]        release_len = 24'(RST_RELEASE);
    logic [15:0]        volume_lvl  = 16'(RST_VOLUME);
    logic signed [15:0] trig_thresh = 16'(RST_THRESHOLD);
    logic [23:0]        hold_limit  = 24'(RST_HOLD);

    // predictor copy of the envelope state
    bit          gate_seen   = 1'b0;
    bit          env_running = 1'b0;
    logic [25:0] sample_count = '0;

    shaped_t shaped_due [$];
    int      mismatches = 0;
    int      burst_left = 0;
    int      quiet_cycles = 0;
    int      pattern_age = 0;
    logic [31:0] ready_pattern = '1;

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [23:0] data);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic plan_row_t word_row(input logic signed [15:0] trig,
                                           input logic signed [15:0] aud);
        plan_row_t row;
        row = '0;
        row.trig = trig;
        row.aud = aud;
        return row;
    endfunction

    function automatic plan_row_t known_row(input logic signed [15:0] trig,
                                            input logic signed [15:0] aud,
                                            input logic [15:0] env,
                                            input logic signed [15:0] shaped);
        plan_row_t row;
        row = word_row(trig, aud);
        row.known = 1'b1;
        row.want.env = env;
        row.want.aud = shaped;
        return row;
    endfunction

    // Directed plan: reset defaults, a short full envelope, zero lengths,
    // held sustain, threshold extremes, spare index, longest lengths.
    plan_row_t directed_plan [47] = '{
        known_row(0, 1000, 0, 0),
        known_row(32767, 32767, 16384, 16383),
        known_row(32767, -32768, 16384, -16384),
        cfg_row(REG_ATTACK, 24'd2),
        cfg_row(REG_DECAY, 24'd2),
        cfg_row(REG_SUSTAIN, 24'd16384),
        cfg_row(REG_RELEASE, 24'd4),
        cfg_row(REG_VOLUME, 24'd32768),
        cfg_row(REG_THRESHOLD, 24'd0),
        cfg_row(REG_HOLD, 24'd0),
        word_row(-32768, 12345),
        known_row(1, -1, 0, 0),
        word_row(32767, 32767),
        word_row(32767, -32768),
        word_row(32767, 21845),
        word_row(32767, -21846),
        word_row(32767, 1),
        word_row(0, 32767),
        word_row(0, -32768),
        word_row(0, 255),
        word_row(0, -256),
        known_row(0, 32767, 0, 0),
        cfg_row(REG_ATTACK, 24'd0),
        cfg_row(REG_DECAY, 24'd0),
        cfg_row(REG_RELEASE, 24'd0),
        cfg_row(REG_SUSTAIN, 24'h00FFFF),
        cfg_row(REG_VOLUME, 24'h00FFFF),
        known_row(32767, 32767, 0, 0),
        cfg_row(REG_RELEASE, 24'd8),
        cfg_row(REG_HOLD, 24'hFFFFFF),
        known_row(-32768, -1, 0, 0),
        known_row(32767, 32767, 16'h8000, 32767),
        known_row(32767, -32768, 16'h8000, -32768),
        cfg_row(REG_THRESHOLD, 24'h007FFF),
        known_row(32767, 5, 16'h8000, 5),
        cfg_row(REG_THRESHOLD, 24'h008000),
        known_row(-32768, -7, 16'h8000, -7),
        known_row(-32767, 0, 16'h8000, 0),
        cfg_row(REG_SPARE, 24'hFFFFFF),
        known_row(0, 100, 16'h8000, 100),
        cfg_row(REG_ATTACK, 24'hFFFFFF),
        cfg_row(REG_DECAY, 24'hFFFFFF),
        cfg_row(REG_RELEASE, 24'hFFFFFF),
        cfg_row(REG_HOLD, 24'd0),
        cfg_row(REG_SUSTAIN, 24'd0),
        known_row(-32768, 32767, 0, 0),
        known_row(32767, -32768, 0, 0)
    };

    // Envelope predictor: advances the gate and counter, returns the shaped word
    function automatic shaped_t shape_sample(input logic signed [15:0] trig,
                                             input logic signed [15:0] aud);
        longint  a, d, r, s, vol, total, t, u, env, eout, aud_l, p, q;
        bit      frozen;
        shaped_t res;
        a = attack_len;
        d = decay_len;
        r = release_len;
        s = (sustain_lvl > ONE) ? ONE : sustain_lvl;
        vol = (volume_lvl > ONE) ? ONE : volume_lvl;
        total = a + d + r;
        frozen = 1'b0;
        res = '0;

        // rising gate restarts the envelope
        if (trig > trig_thresh)
        begin
            if (!gate_seen)
            begin
                sample_count = '0;
                env_running = 1'b1;
                gate_seen = 1'b1;
            end
        end
        else
        begin
            gate_seen = 1'b0;
        end

        t = sample_count;
        if (!(env_running && t < total))
        begin
            env_running = 1'b0;
            return res;
        end

        if (t < a)
        begin
            env = (t * ONE) / a;
        end
        else if (t < a + d)
        begin
            u = t - a;
            env = (ONE * (d - u) + s * u) / d;
        end
        else
        begin
            u = t - a - d;
            if (r < hold_limit)
                env = s;
            else
                env = (s * (r - u)) / r;
            frozen = gate_seen;
        end

        // volume, then audio scaling rounded towards minus infinity
        eout = (env * vol) / ONE;
        aud_l = aud;
        p = aud_l * eout;
        if (p < 0)
            q = -((-p + ONE - 1) / ONE);
        else
            q = p / ONE;
        if (q > ONE - 1)
            q = ONE - 1;
        if (q < -ONE)
            q = -ONE;

        res.env = eout[15:0];
        res.aud = q[15:0];
        if (!frozen)
            sample_count = sample_count + 26'd1;
        return res;
    endfunction

    // trigger level above or at/below the current threshold
    function automatic logic signed [15:0] trig_level(input bit high);
        int lo;
        int hi;
        if (high && trig_thresh == 16'sh7FFF)
            return 16'($urandom);
        lo = high ? int'(trig_thresh) + 1 : -32768;
        hi = high ? 32767 : int'(trig_thresh);
        return 16'(int'($urandom_range(hi + 32768, lo + 32768)) - 32768);
    endfunction

    // mostly short segments so every phase is visited, now and then an extreme
    function automatic logic [23:0] draw_length(input int typical);
        case ($urandom_range(0, 15))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(0, typical));
        endcase
    endfunction

    function automatic logic [23:0] draw_level();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'd32768;
            2:       return 24'($urandom_range(0, 16'hFFFF));
            default: return 24'($urandom_range(0, 32768));
        endcase
    endfunction

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ATTACK:    attack_len = data;
            REG_DECAY:     decay_len = data;
            REG_SUSTAIN:   sustain_lvl = data[15:0];
            REG_RELEASE:   release_len = data;
            REG_VOLUME:    volume_lvl = data[15:0];
            REG_THRESHOLD: trig_thresh = data[15:0];
            REG_HOLD:      hold_limit = data;
            default:       ;
        endcase
        @(posedge clk);
    endtask

    // send one word in bursts with random gaps; predict on acceptance
    task automatic send_word(input logic signed [15:0] trig, input logic signed [15:0] aud,
                             input bit known, input shaped_t known_res);
        int      gap;
        shaped_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sample_ch.valid <= 1'b1;
        sample_ch.trigger_sample <= trig;
        sample_ch.audio_in <= aud;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        burst_left--;
        res = shape_sample(trig, aud);
        if (known)
            res = known_res;
        shaped_due = {shaped_due, res};
    endtask

    // let every outstanding word come back before touching the registers
    task automatic wait_drain();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (shaped_due.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls: rotating pattern, redrawn whenever pattern_age wraps to zero
    always @(posedge clk)
    begin
        if (pattern_age == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = '1;
                1:       ready_pattern = ($urandom & $urandom) | 32'h1;
                default: ready_pattern = $urandom | 32'h1;
            endcase
        end
        else
        begin
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
        end
        pattern_age = (pattern_age + 1) % 96;
        result_ch.ready <= ready_pattern[0];
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        shaped_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (shaped_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word: envelope %0d audio %0d",
                             result_ch.envelope_out, result_ch.audio_out);
                mismatches++;
            end
            else
            begin
                want = shaped_due.pop_front();
                if (result_ch.envelope_out !== want.env || result_ch.audio_out !== want.aud)
                begin
                    if (mismatches < 10)
                        $display("mismatch: envelope exp %0d got %0d, audio exp %0d got %0d",
                                 want.env, result_ch.envelope_out,
                                 want.aud, result_ch.audio_out);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int     random_sent;
        int     phase_words;
        int     hi_words;
        int     lo_words;
        int     span;
        int     noise_words;
        longint total;
        bit     writing;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.trigger_sample = '0;
        sample_ch.audio_in = '0;
        writing = 1'b0;
        random_sent = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                if (!writing)
                    wait_drain();
                writing = 1'b1;
                write_reg(directed_plan[i].idx, directed_plan[i].data);
            end
            else
            begin
                if (writing)
                    cfg_we <= 1'b0;
                writing = 1'b0;
                send_word(directed_plan[i].trig, directed_plan[i].aud,
                          directed_plan[i].known, directed_plan[i].want);
            end
        end

        // random phases: new settings, then notes with random content and some noise
        while (random_sent < RANDOM_WORDS)
        begin
            wait_drain();
            write_reg(REG_ATTACK, draw_length(12));
            write_reg(REG_DECAY, draw_length(12));
            write_reg(REG_SUSTAIN, draw_level());
            write_reg(REG_RELEASE, draw_length(20));
            write_reg(REG_VOLUME, draw_level());
            case ($urandom_range(0, 7))
                0:       write_reg(REG_THRESHOLD, 24'h008000);
                1:       write_reg(REG_THRESHOLD, 24'h007FFF);
                2:       write_reg(REG_THRESHOLD, 24'($urandom_range(0, 16'hFFFF)));
                default: write_reg(REG_THRESHOLD, 24'(16'($urandom_range(0, 4000) - 2000)));
            endcase
            write_reg(REG_HOLD, draw_length(24));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, 24'($urandom));
            cfg_we <= 1'b0;

            total = longint'(attack_len) + longint'(decay_len) + longint'(release_len);
            span = (total > 30) ? 34 : int'(total) + 4;
            phase_words = $urandom_range(40, 120);
            while (phase_words > 0 && random_sent < RANDOM_WORDS)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    // gated note: held high, then released
                    hi_words = $urandom_range(1, span);
                    lo_words = $urandom_range(0, span);
                    repeat (hi_words)
                        send_word(trig_level(1'b1), 16'($urandom), 1'b0, '0);
                    repeat (lo_words)
                        send_word(trig_level(1'b0), 16'($urandom), 1'b0, '0);
                    random_sent += hi_words + lo_words;
                    phase_words -= hi_words + lo_words;
                end
                else
                begin
                    noise_words = $urandom_range(1, 6);
                    repeat (noise_words)
                        send_word(16'($urandom), 16'($urandom), 1'b0, '0);
                    random_sent += noise_words;
                    phase_words -= noise_words;
                end
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/adsr_pkg.sv
src/adsr_in_if.sv
src/adsr_out_if.sv
src/adsr_div.sv
src/adsr_envelope_generator.sv
src/adsr_checker.sv
tb/adsr_envelope_generator_tb.sv
